/* hdl/lts_pkg.sv */
package lts_pkg;

    localparam int TAG_W        = 32;
    localparam int SLOT_W       = 6;
    localparam int KIND_W       = 3;
    localparam int LINK_ENTRIES = 16;
    localparam int DATA_ENTRIES = 32;
    // Wide enough to hold the slot count itself.
    localparam int CNT_W        = SLOT_W + 1;
    // Table select on top of the slot number.
    localparam int ADDR_W       = SLOT_W + 1;
    localparam int RAM_DEPTH    = 2 ** ADDR_W;
    localparam int RANK_DEPTH   = 2 ** SLOT_W;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIND    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VICTIM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd4;

    localparam logic [TAG_W-1:0] TAG_INVALID = 32'hFFFF_FFFF;
    localparam logic [TAG_W-1:0] TAG_TAKEN   = 32'hFFFF_FFFE;
    localparam logic [TAG_W-1:0] RENUMBER_AT = 32'hFFFF_FFFE;
    localparam logic [TAG_W-1:0] TIME_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              table_select;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
    } lts_req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot_out;
        logic [TAG_W-1:0]  prior_tag;
    } lts_rsp_t;

endpackage

/* hdl/lru_tag_store_two_tables_unit.sv */
// Channel   Direction  Ports                        Content
// request   in         s_valid, s_ready, s_data     kind, table_select, tag, slot
// result    out        m_valid, m_ready, m_data     found, slot_out, prior_tag
//
// A request for allocate, find or victim scans the selected table's n slots
// (16 for the link table, 32 for the data table) one by one through the single
// read port of the tag and time memories. Discard all and write tag need no
// scan. When a renumbering falls due before an allocate or find, it comes first:
// a rank scan of the time memory for each slot, then a copy of the ranks back.
// Reset is synchronous and active low; the valid bits stand in for the reset
// contents of the memories, so no clearing pass is needed. A result that is not
// taken holds the block in its final state, but a new request is accepted as
// soon as the previous result sits in the output register.
module lru_tag_store_two_tables_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lts_pkg::lts_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lts_pkg::lts_rsp_t m_data
);

    import lts_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RN_RD   = 4'd1;
    localparam logic [3:0] S_RN_WT   = 4'd2;
    localparam logic [3:0] S_RN_SCAN = 4'd3;
    localparam logic [3:0] S_RN_CP   = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_WB      = 4'd6;
    localparam logic [3:0] S_WT_RD   = 4'd7;
    localparam logic [3:0] S_WT_WB   = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]        st_reg, st_next;
    lts_req_t          req_reg, req_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] didx_reg, didx_next;
    logic [CNT_W-1:0]  s_reg, s_next;
    logic [TAG_W-1:0]  ts_reg, ts_next;
    logic [CNT_W-1:0]  rank_reg, rank_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hidx_reg, hidx_next;
    logic [TAG_W-1:0]  prior_reg, prior_next;
    logic [TAG_W-1:0]  oldest_reg, oldest_next;
    logic [TAG_W-1:0]  ctr_reg [2];
    logic [TAG_W-1:0]  ctr_next [2];
    logic              m_valid_reg, m_valid_next;
    lts_rsp_t          m_data_reg, m_data_next;

    // A cleared valid bit means the entry reads as its reset value.
    logic [RAM_DEPTH-1:0] tag_vld_reg;
    logic [RAM_DEPTH-1:0] time_vld_reg;
    logic                 tag_vq_reg;
    logic                 time_vq_reg;
    logic                 clr_tags;

    logic              tag_we, tag_re, time_we, time_re, rank_we, rank_re;
    logic [ADDR_W-1:0] tag_waddr, tag_raddr, time_waddr, time_raddr;
    logic [TAG_W-1:0]  tag_wdata, time_wdata, tag_q, time_q;
    logic [SLOT_W-1:0] rank_waddr, rank_raddr;
    logic [CNT_W-1:0]  rank_wdata, rank_q;

    logic              sel;
    logic [CNT_W-1:0]  n_w;
    logic [TAG_W-1:0]  tag_rd, time_rd;
    logic [TAG_W-1:0]  ctr_cur;
    logic              can_issue, scan_end;
    logic              rn_due;

    lts_ram #(.DEPTH(RAM_DEPTH), .WIDTH(TAG_W)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_q)
    );

    lts_ram #(.DEPTH(RAM_DEPTH), .WIDTH(TAG_W)) u_time_ram (
        .aclk  (aclk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (time_wdata),
        .re    (time_re),
        .raddr (time_raddr),
        .rdata (time_q)
    );

    lts_ram #(.DEPTH(RANK_DEPTH), .WIDTH(CNT_W)) u_rank_ram (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .re    (rank_re),
        .raddr (rank_raddr),
        .rdata (rank_q)
    );

    assign sel       = req_reg.table_select;
    assign n_w       = sel ? CNT_W'(DATA_ENTRIES) : CNT_W'(LINK_ENTRIES);
    assign tag_rd    = tag_vq_reg ? tag_q : TAG_INVALID;
    assign time_rd   = time_vq_reg ? time_q : '0;
    assign ctr_cur   = ctr_reg[sel];
    assign can_issue = (cnt_reg < n_w);
    assign scan_end  = !pend_reg && !can_issue;
    assign rn_due    = (ctr_reg[s_data.table_select] >= RENUMBER_AT);

    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        st_next      = st_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        didx_next    = cnt_reg[SLOT_W-1:0];
        s_next       = s_reg;
        ts_next      = ts_reg;
        rank_next    = rank_reg;
        hit_next     = hit_reg;
        hidx_next    = hidx_reg;
        prior_next   = prior_reg;
        oldest_next  = oldest_reg;
        ctr_next[0]  = ctr_reg[0];
        ctr_next[1]  = ctr_reg[1];
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        clr_tags     = 1'b0;

        tag_we     = 1'b0;
        tag_waddr  = {sel, hidx_reg};
        tag_wdata  = TAG_TAKEN;
        tag_re     = 1'b0;
        tag_raddr  = {sel, cnt_reg[SLOT_W-1:0]};
        time_we    = 1'b0;
        time_waddr = {sel, hidx_reg};
        time_wdata = ctr_cur;
        time_re    = 1'b0;
        time_raddr = {sel, cnt_reg[SLOT_W-1:0]};
        rank_we    = 1'b0;
        rank_waddr = s_reg[SLOT_W-1:0];
        rank_wdata = rank_reg;
        rank_re    = 1'b0;
        rank_raddr = cnt_reg[SLOT_W-1:0];

        case (st_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    cnt_next    = '0;
                    s_next      = '0;
                    hit_next    = 1'b0;
                    hidx_next   = '0;
                    prior_next  = '0;
                    oldest_next = TIME_MAX;
                    case (s_data.kind)
                        KIND_ALLOC, KIND_FIND: begin
                            st_next = rn_due ? S_RN_RD : S_SCAN;
                        end
                        KIND_VICTIM: begin
                            st_next = S_SCAN;
                        end
                        KIND_DISCARD: begin
                            clr_tags = 1'b1;
                            ctr_next[s_data.table_select] = '0;
                            st_next = S_DONE;
                        end
                        KIND_WRITE: begin
                            if ({1'b0, s_data.slot} <
                                (s_data.table_select ? CNT_W'(DATA_ENTRIES)
                                                     : CNT_W'(LINK_ENTRIES))) begin
                                st_next = S_WT_RD;
                            end else begin
                                st_next = S_DONE;
                            end
                        end
                        default: begin
                            st_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RN_RD: begin
                time_re    = 1'b1;
                time_raddr = {sel, s_reg[SLOT_W-1:0]};
                st_next    = S_RN_WT;
            end
            S_RN_WT: begin
                ts_next   = time_rd;
                cnt_next  = '0;
                rank_next = '0;
                st_next   = S_RN_SCAN;
            end
            S_RN_SCAN: begin
                // Rank of slot s: slots older than it, or as old and earlier.
                if (pend_reg && ((time_rd < ts_reg) ||
                                 ((time_rd == ts_reg) && ({1'b0, didx_reg} < s_reg)))) begin
                    rank_next = rank_reg + 1'b1;
                end
                if (can_issue) begin
                    time_re   = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end else if (scan_end) begin
                    rank_we = 1'b1;
                    s_next  = s_reg + 1'b1;
                    if (s_reg + 1'b1 == n_w) begin
                        cnt_next = '0;
                        st_next  = S_RN_CP;
                    end else begin
                        st_next = S_RN_RD;
                    end
                end
            end
            S_RN_CP: begin
                // Ranks are collected apart and only now replace the times.
                if (pend_reg) begin
                    time_we    = 1'b1;
                    time_waddr = {sel, didx_reg};
                    time_wdata = TAG_W'(rank_q);
                end
                if (can_issue) begin
                    rank_re   = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end else if (scan_end) begin
                    ctr_next[sel] = TAG_W'(n_w);
                    cnt_next      = '0;
                    st_next       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (pend_reg && (((req_reg.kind == KIND_ALLOC) && (tag_rd == TAG_INVALID)) ||
                                 ((req_reg.kind == KIND_FIND) && (tag_rd == req_reg.tag)) ||
                                 ((req_reg.kind == KIND_VICTIM) && (tag_rd == TAG_INVALID)))) begin
                    hit_next   = 1'b1;
                    hidx_next  = didx_reg;
                    prior_next = tag_rd;
                    st_next    = S_WB;
                end else begin
                    if (pend_reg && (req_reg.kind == KIND_VICTIM) && (time_rd < oldest_reg)) begin
                        oldest_next = time_rd;
                        hit_next    = 1'b1;
                        hidx_next   = didx_reg;
                        prior_next  = tag_rd;
                    end
                    if (can_issue) begin
                        tag_re    = 1'b1;
                        time_re   = 1'b1;
                        pend_next = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end else if (scan_end) begin
                        st_next = hit_reg ? S_WB : S_DONE;
                    end
                end
            end
            S_WB: begin
                time_we       = 1'b1;
                tag_we        = (req_reg.kind == KIND_ALLOC);
                ctr_next[sel] = ctr_cur + 1'b1;
                st_next       = S_DONE;
            end
            S_WT_RD: begin
                tag_re    = 1'b1;
                tag_raddr = {sel, req_reg.slot};
                st_next   = S_WT_WB;
            end
            S_WT_WB: begin
                tag_we     = 1'b1;
                tag_waddr  = {sel, req_reg.slot};
                tag_wdata  = req_reg.tag;
                hit_next   = 1'b1;
                hidx_next  = req_reg.slot;
                prior_next = tag_rd;
                st_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.found     = hit_reg;
                    m_data_next.slot_out  = hit_reg ? hidx_reg : '0;
                    m_data_next.prior_tag = hit_reg ? prior_reg : '0;
                    st_next               = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_IDLE;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            ctr_reg[0]   <= '0;
            ctr_reg[1]   <= '0;
            tag_vld_reg  <= '0;
            time_vld_reg <= '0;
        end else begin
            st_reg      <= st_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            ctr_reg[0]  <= ctr_next[0];
            ctr_reg[1]  <= ctr_next[1];
            for (int i = 0; i < RAM_DEPTH; i++) begin
                if (clr_tags && (i[ADDR_W-1] == s_data.table_select)) begin
                    tag_vld_reg[i] <= 1'b0;
                end
            end
            if (tag_we) begin
                tag_vld_reg[tag_waddr] <= 1'b1;
            end
            if (time_we) begin
                time_vld_reg[time_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        cnt_reg    <= cnt_next;
        didx_reg   <= didx_next;
        s_reg      <= s_next;
        ts_reg     <= ts_next;
        rank_reg   <= rank_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        prior_reg  <= prior_next;
        oldest_reg <= oldest_next;
        m_data_reg <= m_data_next;
        if (tag_re) begin
            tag_vq_reg <= tag_vld_reg[tag_raddr];
        end
        if (time_re) begin
            time_vq_reg <= time_vld_reg[time_raddr];
        end
    end

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.found |->
            (m_data_reg.slot_out == '0) && (m_data_reg.prior_tag == '0))
        else $error("miss result carries a slot or tag");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.found |-> ({1'b0, m_data_reg.slot_out} < CNT_W'(DATA_ENTRIES)))
        else $error("result slot beyond the table");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> (st_reg != S_IDLE))
        else $error("request accepted without being worked on");

    a_wb_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_WB) |-> hit_reg)
        else $error("time stamp written without a chosen slot");

endmodule

/* hdl/lts_ram.sv */
module lts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import lts_pkg::*;

    // Clock, reset and the two channels of the tag store.
    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lts_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lts_rsp_t m_data;

    lru_tag_store_two_tables_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // Shadow copy of both tables. Index 0 is the link table, 1 the data table.
    // Only the first LINK_ENTRIES slots of table 0 are ever used.
    logic [TAG_W-1:0] shadow_tags  [2][DATA_ENTRIES];
    logic [TAG_W-1:0] shadow_times [2][DATA_ENTRIES];
    logic [TAG_W-1:0] shadow_clock [2];

    // Responses the block still owes us, oldest first.
    lts_rsp_t pending_rsp[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  long_hold = 1'b0;
    bit  stimulus_done = 1'b0;

    localparam int CYCLE_LIMIT = 1_500_000;

    task automatic report(input string what, input logic [TAG_W-1:0] got,
                          input logic [TAG_W-1:0] want);
        $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got,
                 want);
        mismatches++;
    endtask

    function automatic int table_size(input logic sel);
        return sel ? DATA_ENTRIES : LINK_ENTRIES;
    endfunction

    // Replace every time by its rank once the counter is about to run out.
    // Ties are broken by slot order, so the ranks form a permutation.
    function automatic void rerank_times(input logic sel);
        logic [TAG_W-1:0] ranks [DATA_ENTRIES];
        int n;
        int r;
        n = table_size(sel);
        if (shadow_clock[sel] < RENUMBER_AT)
            return;
        for (int s = 0; s < n; s++) begin
            r = 0;
            for (int t = 0; t < n; t++) begin
                if (shadow_times[sel][t] < shadow_times[sel][s] ||
                    (shadow_times[sel][t] == shadow_times[sel][s] && t < s))
                    r++;
            end
            ranks[s] = TAG_W'(r);
        end
        for (int s = 0; s < n; s++)
            shadow_times[sel][s] = ranks[s];
        shadow_clock[sel] = TAG_W'(n);
    endfunction

    // Apply one request to the shadow tables and return the response it should give.
    function automatic lts_rsp_t predict_lookup(input lts_req_t req);
        lts_rsp_t rsp;
        logic [TAG_W-1:0] oldest;
        logic sel;
        int n;
        int idx;
        bit hit;
        sel = req.table_select;
        n = table_size(sel);
        hit = 1'b0;
        idx = 0;
        rsp = '0;
        case (req.kind)
            KIND_ALLOC: begin
                rerank_times(sel);
                for (int i = 0; i < n && !hit; i++) begin
                    if (shadow_tags[sel][i] == TAG_INVALID) begin
                        hit = 1'b1;
                        idx = i;
                    end
                end
                if (hit) begin
                    rsp.prior_tag = shadow_tags[sel][idx];
                    shadow_tags[sel][idx] = TAG_TAKEN;
                end
            end
            KIND_FIND: begin
                rerank_times(sel);
                for (int i = 0; i < n && !hit; i++) begin
                    if (shadow_tags[sel][i] == req.tag) begin
                        hit = 1'b1;
                        idx = i;
                    end
                end
                if (hit)
                    rsp.prior_tag = shadow_tags[sel][idx];
            end
            KIND_VICTIM: begin
                oldest = TIME_MAX;
                for (int i = 0; i < n; i++) begin
                    if (shadow_tags[sel][i] == TAG_INVALID) begin
                        hit = 1'b1;
                        idx = i;
                        break;
                    end
                    if (shadow_times[sel][i] < oldest) begin
                        oldest = shadow_times[sel][i];
                        hit = 1'b1;
                        idx = i;
                    end
                end
                if (hit)
                    rsp.prior_tag = shadow_tags[sel][idx];
            end
            KIND_DISCARD: begin
                for (int i = 0; i < n; i++)
                    shadow_tags[sel][i] = TAG_INVALID;
                shadow_clock[sel] = '0;
            end
            KIND_WRITE: begin
                if (int'(req.slot) < n) begin
                    hit = 1'b1;
                    idx = req.slot;
                    rsp.prior_tag = shadow_tags[sel][idx];
                    shadow_tags[sel][idx] = req.tag;
                end
            end
            default: ;
        endcase
        // Allocate, find and victim stamp the chosen slot and advance the clock.
        if (hit && (req.kind == KIND_ALLOC || req.kind == KIND_FIND ||
                    req.kind == KIND_VICTIM)) begin
            shadow_times[sel][idx] = shadow_clock[sel];
            shadow_clock[sel] = shadow_clock[sel] + TAG_W'(1);
        end
        rsp.found = hit;
        rsp.slot_out = hit ? idx[SLOT_W-1:0] : '0;
        return rsp;
    endfunction

    // Mostly short gaps, now and then a long one, and often none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request and wait until the block takes it; the expectation is
    // queued at the handshake so that it lines up with the response order.
    task automatic send_request(input lts_req_t req, input bit has_fixed,
                                input lts_rsp_t fixed_rsp);
        lts_rsp_t want;
        s_valid <= 1'b1;
        s_data  <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        want = predict_lookup(req);
        if (has_fixed && want != fixed_rsp)
            report("directed table entry", TAG_W'(fixed_rsp), TAG_W'(want));
        pending_rsp.push_back(want);
    endtask

    // Draw the tag so that finds mostly hit: reuse a tag already in the table,
    // sometimes the two reserved values, sometimes anything at all.
    function automatic logic [TAG_W-1:0] pick_tag(input logic sel);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return shadow_tags[sel][$urandom_range(0, table_size(sel) - 1)];
        if (r < 65)
            return TAG_INVALID;
        if (r < 70)
            return TAG_TAKEN;
        if (r < 85)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    function automatic lts_req_t random_request();
        lts_req_t req;
        int r;
        req.table_select = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 22)
            req.kind = KIND_ALLOC;
        else if (r < 50)
            req.kind = KIND_FIND;
        else if (r < 68)
            req.kind = KIND_VICTIM;
        else if (r < 71)
            req.kind = KIND_DISCARD;
        else if (r < 97)
            req.kind = KIND_WRITE;
        else
            req.kind = KIND_W'($urandom_range(5, 7));
        req.tag = pick_tag(req.table_select);
        // Mostly in-range slot numbers, some beyond the table.
        if ($urandom_range(0, 9) < 8)
            req.slot = SLOT_W'($urandom_range(0, table_size(req.table_select) - 1));
        else
            req.slot = SLOT_W'($urandom);
        return req;
    endfunction

    // Directed table: kind, table, tag, slot, whether the response is written
    // in, and that response.
    typedef struct {
        lts_req_t req;
        bit       has_fixed;
        lts_rsp_t rsp;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic directed_row_t row(input logic [KIND_W-1:0] k, input logic sel,
                                          input logic [TAG_W-1:0] tg,
                                          input int sl, input int fixed,
                                          input int f, input int so,
                                          input logic [TAG_W-1:0] pt);
        directed_row_t d;
        d.req = '{kind: k, table_select: sel, tag: tg, slot: SLOT_W'(sl)};
        d.has_fixed = (fixed != 0);
        d.rsp = '{found: (f != 0), slot_out: SLOT_W'(so), prior_tag: pt};
        return d;
    endfunction

    // Fill every slot of the table with write-tag requests.
    task automatic fill_table(input logic sel);
        for (int i = 0; i < table_size(sel); i++)
            send_request('{kind: KIND_WRITE, table_select: sel, tag: 32'h100 + i,
                           slot: SLOT_W'(i)}, 1'b0, '0);
    endtask

    initial begin
        lts_rsp_t none;
        int gap;
        none = '0;
        for (int t = 0; t < 2; t++) begin
            for (int i = 0; i < DATA_ENTRIES; i++) begin
                shadow_tags[t][i]  = TAG_INVALID;
                shadow_times[t][i] = '0;
            end
            shadow_clock[t] = '0;
        end

        // After reset: find of an invalid tag hits slot 0, victim takes slot 0.
        directed_rows.push_back(row(KIND_FIND, 1'b0, TAG_INVALID, 0, 1, 1, 0, TAG_INVALID));
        directed_rows.push_back(row(KIND_FIND, 1'b1, 32'h0, 0, 1, 0, 0, 0));
        directed_rows.push_back(row(KIND_VICTIM, 1'b1, 32'h0, 0, 1, 1, 0, TAG_INVALID));
        directed_rows.push_back(row(KIND_ALLOC, 1'b0, 32'h0, 0, 1, 1, 0, TAG_INVALID));
        directed_rows.push_back(row(KIND_ALLOC, 1'b0, 32'h0, 0, 1, 1, 1, TAG_INVALID));
        // Write-tag at the extremes; slots beyond the table are ignored.
        directed_rows.push_back(row(KIND_WRITE, 1'b0, 32'hFFFF_FFFD, 15, 1, 1, 15,
                                    TAG_INVALID));
        directed_rows.push_back(row(KIND_WRITE, 1'b0, 32'h1, 16, 1, 0, 0, 0));
        directed_rows.push_back(row(KIND_WRITE, 1'b1, 32'h0, 31, 1, 1, 31, TAG_INVALID));
        directed_rows.push_back(row(KIND_WRITE, 1'b1, 32'h2, 63, 1, 0, 0, 0));
        directed_rows.push_back(row(KIND_FIND, 1'b1, 32'h0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(KIND_FIND, 1'b0, 32'hFFFF_FFFD, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(KIND_FIND, 1'b0, TAG_TAKEN, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(KIND_VICTIM, 1'b0, 32'h0, 0, 0, 0, 0, 0));
        // Unused kind codes answer with nothing found.
        directed_rows.push_back(row(3'd5, 1'b0, 32'hFFFF_FFFF, 63, 1, 0, 0, 0));
        directed_rows.push_back(row(3'd6, 1'b1, 32'h0, 0, 1, 0, 0, 0));
        directed_rows.push_back(row(3'd7, 1'b1, 32'hAAAA_5555, 42, 1, 0, 0, 0));
        // Discard, then the table behaves as after reset apart from times.
        directed_rows.push_back(row(KIND_DISCARD, 1'b0, 32'h0, 0, 1, 0, 0, 0));
        directed_rows.push_back(row(KIND_ALLOC, 1'b0, 32'h0, 0, 1, 1, 0, TAG_INVALID));
        directed_rows.push_back(row(KIND_DISCARD, 1'b1, 32'h5555_AAAA, 21, 1, 0, 0, 0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].has_fixed,
                         directed_rows[i].rsp);
            gap = pick_gap();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end

        // A full table with no invalid slot: allocate fails, victim picks the oldest.
        fill_table(1'b0);
        for (int i = 0; i < 3; i++)
            send_request('{kind: KIND_FIND, table_select: 1'b0, tag: 32'h100 + i,
                           slot: '0}, 1'b0, none);
        send_request('{kind: KIND_ALLOC, table_select: 1'b0, tag: '0, slot: '0},
                     1'b1, none);
        send_request('{kind: KIND_VICTIM, table_select: 1'b0, tag: '0, slot: '0},
                     1'b0, none);

        // Random part. The receiver takes a long break once, early on, while
        // requests keep coming so that the block fills and stalls its input.
        for (int n = 0; n < 1230; n++) begin
            if (n == 40)
                long_hold = 1'b1;
            send_request(random_request(), 1'b0, none);
            if ($urandom_range(0, 3) != 0 || n % 200 < 30) begin
                // back-to-back: valid stays high for the next request
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Reaching a renumbering by stamping the clock up to its end would take
    // billions of requests, so it is covered only when the block's own counter
    // gets there; the shadow model follows it regardless.

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin
        int hold;
        int gap;
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (long_hold && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                hold = 0;
                while (hold < 400) begin
                    @(posedge aclk);
                    hold++;
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if ($urandom_range(0, 2) == 0) begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Response checker: compares each accepted response with the oldest expectation.
    always @(posedge aclk) begin
        lts_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                report("response with nothing expected", TAG_W'(m_data), '0);
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.found !== want.found)
                    report("found", TAG_W'(m_data.found), TAG_W'(want.found));
                if (m_data.slot_out !== want.slot_out)
                    report("slot_out", TAG_W'(m_data.slot_out), TAG_W'(want.slot_out));
                if (m_data.prior_tag !== want.prior_tag)
                    report("prior_tag", m_data.prior_tag, want.prior_tag);
            end
        end
    end

    // End of run and timeout.
    initial begin
        int drain;
        drain = 0;
        while (!(stimulus_done && pending_rsp.size() == 0) && cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        while (drain < 100 && cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
        end else if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

endmodule
